@@ design/json_frame_completion_detector_defines.svh @@
// ---------------------------------------------------------------------------
// JSON frame completion detector: assertion macros
// Shared concurrent assertion forms, clocked on clk_i with reset disable.
// ---------------------------------------------------------------------------
`ifndef JSON_FRAME_COMPLETION_DETECTOR_DEFINES_SVH
`define JSON_FRAME_COMPLETION_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define JFCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JFCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/jfcd_pkg.sv @@
// ---------------------------------------------------------------------------
// JSON frame completion detector package
// Sizes, character codes, status and register codes, frame state type.
// ---------------------------------------------------------------------------
package jfcd_pkg;

  localparam int unsigned BUFFER_SIZE = 1024;
  localparam int unsigned COUNT_W     = $clog2(BUFFER_SIZE);
  localparam int unsigned DEPTH_W     = COUNT_W;
  localparam int unsigned MINLEN_W    = 10;
  localparam int unsigned TIMEOUT_W   = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned STATUS_W    = 3;

  // Byte count at which the buffer is full; a byte arriving at this count is dropped.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(BUFFER_SIZE - 1);

  localparam logic [MINLEN_W-1:0]  MINLEN_RESET  = MINLEN_W'(20);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [STATUS_W-1:0] {
    ST_WAITING  = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_TIMEOUT  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TICK     = 3'd4
  } status_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_MIN_FRAME_LENGTH = 1'b0,
    REG_TIMEOUT_MS       = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic                 waiting;
    logic [TIMEOUT_W-1:0] elapsed;
    logic [DEPTH_W-1:0]   brace;
    logic [DEPTH_W-1:0]   bracket;
    logic                 in_str;
    logic [7:0]           prev;
    logic                 open;
    logic                 broken;
  } frame_t;

endpackage

@@ design/json_frame_completion_detector.sv @@
// ---------------------------------------------------------------------------
// JSON frame completion detector
// Per-byte brace/bracket/string scanner that flags the end of a JSON frame.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per transaction: tuser = command (byte or
//   millisecond tick), tdata = received byte. Master stream returns exactly
//   one result per input transaction: tuser = status, tdata = frame length,
//   byte index and byte value for the downstream frame buffer.
//   An item accepted at one edge shows its result on the master side after
//   that edge. Throughput is one item per cycle while the receiver keeps up;
//   the frame state update is a single pass of compares and counter increments
//   between the input port and the result register.
//   When the receiver stalls, the result register holds its transaction and
//   s_axis_tready drops until that result is taken; when the result is taken
//   in the same cycle, a new item is accepted alongside it.
//   Reset clears the frame state and the result valid, and loads the
//   registers with min_frame_length = 20 and timeout_ms = 10000.
//   Write configuration only while no result is pending.
// ---------------------------------------------------------------------------
`include "json_frame_completion_detector_defines.svh"

module json_frame_completion_detector
  import jfcd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] cmd
  // Result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] frame_length,
                                                 // [19:10] byte_index,
                                                 // [27:20] byte_value, [31:28] 0
  output logic [STATUS_W-1:0]    m_axis_tuser    // [2:0] status
);

  // Configuration registers
  logic [MINLEN_W-1:0]  min_len_q;
  logic [TIMEOUT_W-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MINLEN_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MIN_FRAME_LENGTH: min_len_q <= cfg_data_i[MINLEN_W-1:0];
        REG_TIMEOUT_MS:       timeout_q <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees up when empty or being drained.
  logic in_fire;
  logic out_fire;

  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  frame_t frame_q, frame_d;

  logic [7:0] byte_in;
  assign byte_in = s_axis_tdata[7:0];

  // Structural scan of the incoming byte; a broken scan freezes.
  logic               str_nxt;
  logic [DEPTH_W-1:0] brace_nxt;
  logic [DEPTH_W-1:0] bracket_nxt;
  logic               broken_nxt;

  always_comb begin
    str_nxt     = frame_q.in_str;
    brace_nxt   = frame_q.brace;
    bracket_nxt = frame_q.bracket;
    broken_nxt  = frame_q.broken;
    if (!frame_q.broken) begin
      // Open a string on any quote; close it unless escaped.
      if (byte_in == CH_QUOTE) begin
        if (!frame_q.in_str) begin
          str_nxt = 1'b1;
        end else if (frame_q.prev != CH_BACKSLASH) begin
          str_nxt = 1'b0;
        end
      end
      if (!str_nxt) begin
        if (byte_in == CH_LBRACE) begin
          brace_nxt = frame_q.brace + DEPTH_W'(1);
        end else if (byte_in == CH_RBRACE) begin
          if (frame_q.brace == '0) begin
            broken_nxt = 1'b1;
          end else begin
            brace_nxt = frame_q.brace - DEPTH_W'(1);
          end
        end else if (byte_in == CH_LBRACKET) begin
          bracket_nxt = frame_q.bracket + DEPTH_W'(1);
        end else if (byte_in == CH_RBRACKET) begin
          if (frame_q.bracket == '0) begin
            broken_nxt = 1'b1;
          end else begin
            bracket_nxt = frame_q.bracket - DEPTH_W'(1);
          end
        end
      end
    end
  end

  // Counters and completion check
  logic [COUNT_W-1:0]   count_inc;
  logic [TIMEOUT_W-1:0] elapsed_inc;
  logic                 open_nxt;
  logic                 done;

  assign count_inc   = frame_q.count + COUNT_W'(1);
  assign elapsed_inc = (frame_q.elapsed == '1) ? frame_q.elapsed
                                               : frame_q.elapsed + TIMEOUT_W'(1);
  assign open_nxt    = (frame_q.count == '0) ? (byte_in == CH_LBRACE) : frame_q.open;
  assign done        = (MINLEN_W'(count_inc) >= min_len_q) && open_nxt
                       && (byte_in == CH_RBRACE) && (brace_nxt == '0)
                       && (bracket_nxt == '0) && !str_nxt && !broken_nxt;

  status_e            status_d;
  logic [COUNT_W-1:0] len_d;
  logic [COUNT_W-1:0] idx_d;
  logic [7:0]         val_d;

  always_comb begin
    frame_d  = frame_q;
    status_d = ST_TICK;
    len_d    = frame_q.count;
    idx_d    = '0;
    val_d    = '0;
    if (cmd_e'(s_axis_tuser) == CMD_TICK) begin
      // Count ticks only while a frame is waiting.
      if (frame_q.waiting) begin
        if (elapsed_inc >= timeout_q) begin
          frame_d  = '0;
          status_d = ST_TIMEOUT;
        end else begin
          frame_d.elapsed = elapsed_inc;
        end
      end
    end else if (frame_q.count >= COUNT_LIMIT) begin
      // Drop the byte and discard the frame.
      frame_d  = '0;
      status_d = ST_OVERFLOW;
    end else begin
      idx_d = frame_q.count;
      val_d = byte_in;
      len_d = count_inc;
      if (done) begin
        frame_d  = '0;
        status_d = ST_COMPLETE;
      end else begin
        frame_d.count   = count_inc;
        frame_d.waiting = 1'b1;
        frame_d.elapsed = frame_q.waiting ? frame_q.elapsed : '0;
        frame_d.brace   = brace_nxt;
        frame_d.bracket = bracket_nxt;
        frame_d.in_str  = str_nxt;
        frame_d.prev    = byte_in;
        frame_d.open    = open_nxt;
        frame_d.broken  = broken_nxt;
        status_d        = ST_WAITING;
      end
    end
  end

  // Frame state and result valid
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        frame_q <= frame_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled.
  status_e            status_q;
  logic [COUNT_W-1:0] len_q;
  logic [COUNT_W-1:0] idx_q;
  logic [7:0]         val_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {4'b0000, val_q, idx_q, len_q};

  // Assertions
  `JFCD_ASSERT_NOW(a_idle_clean, !frame_q.waiting,
      (frame_q.count == '0) && (frame_q.elapsed == '0) && !frame_q.broken,
      "idle frame state is not clear")
  `JFCD_ASSERT_NOW(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
      "input accepted while result is stalled")
  `JFCD_ASSERT_NOW(a_complete_brace, m_axis_tvalid && (status_q == ST_COMPLETE),
      val_q == CH_RBRACE, "frame completed on a byte other than closing brace")
  `JFCD_ASSERT_NEXT(a_clear_after_end,
      in_fire && ((status_d == ST_COMPLETE) || (status_d == ST_TIMEOUT)
                  || (status_d == ST_OVERFLOW)),
      !frame_q.waiting && (frame_q.count == '0), "frame not cleared after its end")

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// JSON frame completion detector testbench
// Drives received bytes and millisecond ticks into the detector and compares
// every result transaction with a cycle-free model of the frame scanner. It
// covers directed corner cases, a full-buffer frame, a tick timeout,
// output back-pressure and random JSON-like traffic under several idle mixes.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import jfcd_pkg::*;

  // Watchdog: cycle limit for the whole run.
  localparam int unsigned CYCLE_LIMIT = 100_000;
  // Receiver hold-off length for the back-pressure test.
  localparam int unsigned HOLD_CYCLES = 300;
  // Result latency plus margin before the block counts as quiet.
  localparam int unsigned SETTLE_CYCLES = 3;

  typedef struct packed {
    status_e            status;
    logic [COUNT_W-1:0] frame_len;
    logic [COUNT_W-1:0] byte_idx;
    logic [7:0]         byte_val;
  } frame_result_t;

  typedef enum {
    TOK_OPEN_OBJECT,
    TOK_OPEN_ARRAY,
    TOK_CLOSE,
    TOK_STRING,
    TOK_PLAIN
  } token_e;

  typedef enum {
    DMG_STRAY_CLOSE,
    DMG_TRUNCATE,
    DMG_BAD_START,
    DMG_NOISE
  } damage_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] data_byte
  logic                   s_axis_tuser;   // [0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [9:0] frame_length, [19:10] byte_index,
                                          // [27:20] byte_value, [31:28] zero
  logic [STATUS_W-1:0]    m_axis_tuser;   // [2:0] status

  json_frame_completion_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Scanner state and register copies, advanced once per accepted transaction.
  frame_t               frame_state;
  logic [MINLEN_W-1:0]  min_length_cfg;
  logic [TIMEOUT_W-1:0] timeout_cfg;

  frame_result_t pending_results[$];
  logic [7:0]    frame_plan[$];

  int          sender_idle_pct;
  int          receiver_idle_pct;
  bit          hold_request;
  int          error_count;
  int unsigned items_accepted;

  // -------------------------------------------------------------------------
  // Clock and watchdog
  // -------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("testbench NOT OK");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Frame scanner prediction
  // -------------------------------------------------------------------------
  // Advance the frame state by one item and return the result it produces.
  function automatic frame_result_t predict_frame_event(cmd_e cmd, logic [7:0] b);
    frame_result_t      r;
    logic [COUNT_W-1:0] idx;
    r.status    = ST_TICK;
    r.frame_len = frame_state.count;
    r.byte_idx  = '0;
    r.byte_val  = '0;

    if (cmd == CMD_TICK) begin
      // Ticks only age a frame that has started; the counter saturates.
      if (frame_state.waiting) begin
        if (frame_state.elapsed != '1) frame_state.elapsed++;
        if (frame_state.elapsed >= timeout_cfg) begin
          r.status    = ST_TIMEOUT;
          frame_state = '0;
        end
      end
      return r;
    end

    // Buffer full: drop the byte and throw the frame away.
    if (frame_state.count >= COUNT_LIMIT) begin
      r.status    = ST_OVERFLOW;
      frame_state = '0;
      return r;
    end

    idx = frame_state.count;
    frame_state.count++;
    if (!frame_state.waiting) begin
      frame_state.waiting = 1'b1;
      frame_state.elapsed = '0;
    end
    if (idx == 0) frame_state.open = (b == CH_LBRACE);

    // Once a depth has gone negative the scanner freezes until the frame clears.
    if (!frame_state.broken) begin
      if (b == CH_QUOTE) begin
        if (!frame_state.in_str) frame_state.in_str = 1'b1;
        else if (frame_state.prev != CH_BACKSLASH) frame_state.in_str = 1'b0;
      end
      if (!frame_state.in_str) begin
        if (b == CH_LBRACE) begin
          frame_state.brace++;
        end else if (b == CH_RBRACE) begin
          if (frame_state.brace == 0) frame_state.broken = 1'b1;
          else frame_state.brace--;
        end else if (b == CH_LBRACKET) begin
          frame_state.bracket++;
        end else if (b == CH_RBRACKET) begin
          if (frame_state.bracket == 0) frame_state.broken = 1'b1;
          else frame_state.bracket--;
        end
      end
    end
    frame_state.prev = b;

    r.frame_len = frame_state.count;
    r.byte_idx  = idx;
    r.byte_val  = b;
    if (frame_state.count >= min_length_cfg && frame_state.open && b == CH_RBRACE &&
        frame_state.brace == 0 && frame_state.bracket == 0 &&
        !frame_state.in_str && !frame_state.broken) begin
      r.status    = ST_COMPLETE;
      frame_state = '0;
    end else begin
      r.status = ST_WAITING;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random or forced stalls, and the checker
  // -------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      // Take a hold-off request and count it down here, independent of the sender.
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Compare every result transaction with the oldest prediction.
  initial begin
    frame_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, tdata 0x%08h", m_axis_tuser, m_axis_tdata);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("frame_length", want.frame_len, m_axis_tdata[9:0]);
          check_field("byte_index", want.byte_idx, m_axis_tdata[19:10]);
          check_field("byte_value", want.byte_val, m_axis_tdata[27:20]);
          check_field("tdata_pad", 0, m_axis_tdata[31:28]);
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------
  // Offer one item, idling at random first, and predict it once accepted.
  task automatic send_item(cmd_e cmd, logic [7:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_frame_event(cmd, value));
    items_accepted++;
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) send_item(CMD_BYTE, text[i]);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(reg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == REG_MIN_FRAME_LENGTH) min_length_cfg = data[MINLEN_W-1:0];
    else timeout_cfg = data;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
  endtask

  // Build a balanced JSON-like frame with nested objects, arrays and strings.
  task automatic plan_json_frame();
    logic [7:0] closers[$];
    logic [7:0] c;
    token_e     tok;
    frame_plan = {};
    frame_plan.push_back(CH_LBRACE);
    closers.push_back(CH_RBRACE);
    repeat ($urandom_range(12)) begin
      tok = token_e'($urandom_range(4));
      case (tok)
        TOK_OPEN_OBJECT: begin
          frame_plan.push_back(CH_LBRACE);
          closers.push_back(CH_RBRACE);
        end
        TOK_OPEN_ARRAY: begin
          frame_plan.push_back(CH_LBRACKET);
          closers.push_back(CH_RBRACKET);
        end
        TOK_CLOSE: begin
          if (closers.size() > 1) frame_plan.push_back(closers.pop_back());
        end
        TOK_STRING: begin
          // Any byte may sit in a string; escape quotes, turn backslashes into \n.
          frame_plan.push_back(CH_QUOTE);
          repeat ($urandom_range(6)) begin
            c = 8'($urandom);
            if (c == CH_QUOTE) begin
              frame_plan.push_back(CH_BACKSLASH);
              frame_plan.push_back(c);
            end else if (c == CH_BACKSLASH) begin
              frame_plan.push_back(CH_BACKSLASH);
              frame_plan.push_back(8'h6E);
            end else begin
              frame_plan.push_back(c);
            end
          end
          frame_plan.push_back(CH_QUOTE);
        end
        default: begin
          // Digits and colons: bytes the scanner passes over.
          repeat ($urandom_range(1, 5)) frame_plan.push_back(8'($urandom_range(8'h30, 8'h3A)));
        end
      endcase
    end
    while (closers.size() != 0) frame_plan.push_back(closers.pop_back());
  endtask

  // Break the planned frame: stray closer, missing end, bad start or pure noise.
  task automatic damage_frame_plan();
    int      pos;
    damage_e kind;
    pos  = $urandom_range(frame_plan.size() - 1);
    kind = damage_e'($urandom_range(3));
    case (kind)
      DMG_STRAY_CLOSE: frame_plan.insert(pos, $urandom_range(1) ? CH_RBRACE : CH_RBRACKET);
      DMG_TRUNCATE:    void'(frame_plan.pop_back());
      DMG_BAD_START:   frame_plan[0] = 8'($urandom);
      default: begin
        frame_plan = {};
        repeat ($urandom_range(1, 20)) frame_plan.push_back(8'($urandom));
      end
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Short hand-picked sequences for each special case of the scanner.
  task automatic test_directed_cases();
    // Tick before any byte: no event, nothing changes.
    send_item(CMD_TICK, 8'hA5);
    // No length limit: the smallest frame completes.
    write_config(REG_MIN_FRAME_LENGTH, 16'h0000);
    send_text("{}");
    // Closing bracket at depth zero freezes the scanner; zero timeout clears it.
    write_config(REG_TIMEOUT_MS, 16'h0000);
    send_text("{]}");
    send_item(CMD_TICK, 8'h00);
    // Escaped quote keeps the string open, so the inner brace is skipped.
    write_config(REG_MIN_FRAME_LENGTH, 16'h0001);
    write_config(REG_TIMEOUT_MS, 16'h0001);
    send_text("{\"\\\"}\"}");
    // Extreme byte values, then a timeout on the first tick.
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_TICK, 8'hFF);
    // Balanced frame shorter than the minimum: waits, then times out.
    write_config(REG_MIN_FRAME_LENGTH, 16'h0005);
    write_config(REG_TIMEOUT_MS, 16'h0002);
    send_text("{[]}");
    send_item(CMD_TICK, 8'h55);
    send_item(CMD_TICK, 8'hAA);
  endtask

  // Fill every slot of the buffer, then drop a closing brace that would end the frame.
  task automatic test_full_buffer();
    write_config(REG_MIN_FRAME_LENGTH, 16'hFFFF);
    write_config(REG_TIMEOUT_MS, 16'hFFFF);
    send_item(CMD_BYTE, CH_LBRACE);
    repeat (COUNT_LIMIT - 1) send_item(CMD_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
    send_item(CMD_BYTE, CH_RBRACE);
    send_item(CMD_TICK, 8'($urandom));
  endtask

  // Tick timeout: the frame survives one tick fewer than the limit and drops on the next.
  task automatic test_tick_timeout();
    write_config(REG_TIMEOUT_MS, 16'd40);
    while (frame_state.waiting) send_item(CMD_TICK, 8'($urandom));
    send_item(CMD_BYTE, CH_LBRACE);
    repeat (39) send_item(CMD_TICK, 8'($urandom));
    send_item(CMD_TICK, 8'($urandom));
  endtask

  // Hold off the receiver while the sender keeps offering items.
  task automatic test_output_stall();
    write_config(REG_MIN_FRAME_LENGTH, 16'h0000);
    hold_request = 1'b1;
    repeat (4) begin
      plan_json_frame();
      foreach (frame_plan[k]) send_item(CMD_BYTE, frame_plan[k]);
    end
  endtask

  // Mostly well-formed frames with random content, some damaged, ticks mixed in.
  task automatic test_random_traffic(int sender_pct, int receiver_pct, int unsigned item_goal);
    int unsigned start;
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
    write_config(REG_MIN_FRAME_LENGTH, {6'($urandom), 10'($urandom_range(0, 24))});
    write_config(REG_TIMEOUT_MS, 16'($urandom_range(6, 80)));
    start = items_accepted;
    while (items_accepted - start < item_goal) begin
      plan_json_frame();
      if ($urandom_range(3) == 0) damage_frame_plan();
      foreach (frame_plan[k]) begin
        if ($urandom_range(24) == 0) send_item(CMD_TICK, 8'($urandom));
        send_item(CMD_BYTE, frame_plan[k]);
      end
      // Flush a leftover frame with ticks most of the time; else let it pile up.
      if (frame_state.waiting && $urandom_range(9) != 0) begin
        while (frame_state.waiting) send_item(CMD_TICK, 8'($urandom));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MIN_FRAME_LENGTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_BYTE;
    frame_state       = '0;
    min_length_cfg    = MINLEN_RESET;
    timeout_cfg       = TIMEOUT_RESET;
    hold_request      = 1'b0;
    error_count       = 0;
    items_accepted    = 0;
    sender_idle_pct   = 13;
    receiver_idle_pct = 67;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_full_buffer();
    test_random_traffic(13, 67, 80);
    test_random_traffic(67, 13, 80);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_tick_timeout();
    test_output_stall();
    test_random_traffic(0, 0, 80);

    wait_for_results();
    if (error_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

@@ json_frame_completion_detector.f @@
+incdir+design
design/jfcd_pkg.sv
design/json_frame_completion_detector.sv
tb/testbench.sv
